// ===== src/mdalu_pkg.sv =====
// Package: types, operation codes and the Q16.16 product helper for the multidual ALU.
package mdalu_pkg;

  localparam int unsigned COMP_W = 32;
  localparam int unsigned NCOMP  = 8;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef enum logic [2:0] {
    KIND_LOAD_B = 3'd0,
    KIND_LOAD_C = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_SUB    = 3'd3,
    KIND_NEG    = 3'd4,
    KIND_MUL    = 3'd5,
    KIND_TMUL   = 3'd6,
    KIND_FMA    = 3'd7
  } kind_t;

  // Component slot (real, e1, e2, e3, e12, e13, e23, e123) <-> direction bit mask.
  // The map is its own inverse.
  localparam logic [2:0] COMP_MASK [NCOMP] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
  };

  function automatic comp_t qmul(input comp_t a, input comp_t b);
    logic signed [2*COMP_W-1:0] p;
    p = $signed({{COMP_W{a[COMP_W-1]}}, a}) * $signed({{COMP_W{b[COMP_W-1]}}, b});
    return p[COMP_W+15:16];
  endfunction

endpackage

// ===== src/mdalu_in_if.sv =====
// Interfaces: input and result channels of the multidual ALU.
interface mdalu_in_if;
  import mdalu_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  comp_t       x_real;
  comp_t       x_e1;
  comp_t       x_e2;
  comp_t       x_e3;
  comp_t       x_e12;
  comp_t       x_e13;
  comp_t       x_e23;
  comp_t       x_e123;

  modport source (output valid, kind, x_real, x_e1, x_e2, x_e3, x_e12, x_e13, x_e23, x_e123,
                  input ready);
  modport sink   (input valid, kind, x_real, x_e1, x_e2, x_e3, x_e12, x_e13, x_e23, x_e123,
                  output ready);
endinterface

interface mdalu_out_if;
  import mdalu_pkg::*;

  logic   valid;
  logic   ready;
  comp_t  y_real;
  comp_t  y_e1;
  comp_t  y_e2;
  comp_t  y_e3;
  comp_t  y_e12;
  comp_t  y_e13;
  comp_t  y_e23;
  comp_t  y_e123;

  modport source (output valid, y_real, y_e1, y_e2, y_e3, y_e12, y_e13, y_e23, y_e123,
                  input ready);
  modport sink   (input valid, y_real, y_e1, y_e2, y_e3, y_e12, y_e13, y_e23, y_e123,
                  output ready);
endinterface

// ===== src/multidual_order3_alu.sv =====
// Top level: Q16.16 multidual (three directions) ALU with operand and addend registers.
//
// Channels: in_ch carries one word per item (kind plus the eight components
// of x); out_ch returns exactly one word per item, in order. Both use
// valid/ready; a word moves on a rising edge with both high.
// Kinds: load B, load C (both echo x), x+B, x-B, -x, x*B, truncated x*B
// (orders 2 and 3 only), and x*B+C. Products keep bits 47:16; sums wrap.
// Each word passes through the input register, the product register and the result
// register on its way to out_ch. Throughput: one word per cycle while out_ch takes its words.
// The 27 component products are formed in parallel from the input register;
// the per-component adder tree sits between product and result registers.
// The three stages advance together: when out_ch holds a word that is not
// taken, in_ch.ready drops and everything holds. A load takes effect for
// every later word.
// Reset: clears stage valid bits and sets B and C to zero.
module multidual_order3_alu (
  input  logic                 clk,
  input  logic                 rst_n,
  mdalu_in_if.sink             in_ch,
  mdalu_out_if.source          out_ch
);
  import mdalu_pkg::*;

  logic   en;
  logic   in_acc;
  comp_t  in_x [NCOMP];

  comp_t  b_r [NCOMP];
  comp_t  c_r [NCOMP];

  logic   s1_vld_r;
  kind_t  s1_kind_r;
  comp_t  s1_x_r [NCOMP];

  comp_t  xm [NCOMP];
  comp_t  bm [NCOMP];
  comp_t  prod [NCOMP][NCOMP];
  comp_t  lin [NCOMP];

  logic   s2_vld_r;
  kind_t  s2_kind_r;
  comp_t  s2_prod_r [NCOMP][NCOMP];
  comp_t  s2_lin_r [NCOMP];
  comp_t  s2_c_r [NCOMP];

  comp_t  res [NCOMP];

  logic   out_vld_r;
  comp_t  out_y_r [NCOMP];

  assign en         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc     = in_ch.valid && en;

  assign in_x[0] = in_ch.x_real;
  assign in_x[1] = in_ch.x_e1;
  assign in_x[2] = in_ch.x_e2;
  assign in_x[3] = in_ch.x_e3;
  assign in_x[4] = in_ch.x_e12;
  assign in_x[5] = in_ch.x_e13;
  assign in_x[6] = in_ch.x_e23;
  assign in_x[7] = in_ch.x_e123;

  // operand and addend registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOMP; i++) begin
        b_r[i] <= '0;
        c_r[i] <= '0;
      end
    end else if (in_acc) begin
      if (kind_t'(in_ch.kind) == KIND_LOAD_B) begin
        b_r <= in_x;
      end
      if (kind_t'(in_ch.kind) == KIND_LOAD_C) begin
        c_r <= in_x;
      end
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= kind_t'(in_ch.kind);
      s1_x_r    <= in_x;
    end
  end

  // reorder into direction-mask order
  always_comb begin
    for (int m = 0; m < NCOMP; m++) begin
      xm[m] = s1_x_r[COMP_MASK[m]];
      bm[m] = b_r[COMP_MASK[m]];
    end
  end

  // x[s] * B[m^s] for every subset s of mask m
  for (genvar gm = 0; gm < NCOMP; gm++) begin : g_mask
    for (genvar gs = 0; gs < NCOMP; gs++) begin : g_sub
      localparam logic [2:0] M = 3'(gm);
      localparam logic [2:0] S = 3'(gs);
      if ((S & M) == S) begin : g_term
        assign prod[gm][gs] = qmul(xm[S], bm[M ^ S]);
      end else begin : g_none
        assign prod[gm][gs] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      case (s1_kind_r)
        KIND_ADD: lin[i] = s1_x_r[i] + b_r[i];
        KIND_SUB: lin[i] = s1_x_r[i] - b_r[i];
        KIND_NEG: lin[i] = '0 - s1_x_r[i];
        default:  lin[i] = s1_x_r[i];
      endcase
    end
  end

  // stage 2: product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_vld_r) begin
      s2_kind_r <= s1_kind_r;
      s2_prod_r <= prod;
      s2_lin_r  <= lin;
      s2_c_r    <= c_r;
    end
  end

  // per-component sums; truncated product drops terms that touch the real part
  always_comb begin
    for (int m = 0; m < NCOMP; m++) begin
      res[COMP_MASK[m]] = (s2_kind_r == KIND_FMA) ? s2_c_r[COMP_MASK[m]] : '0;
      for (int s = 0; s < NCOMP; s++) begin
        if (((3'(s) & 3'(m)) == 3'(s)) &&
            ((s2_kind_r != KIND_TMUL) || ((s != 0) && (s != m)))) begin
          res[COMP_MASK[m]] = res[COMP_MASK[m]] + s2_prod_r[m][s];
        end
      end
      if (!((s2_kind_r == KIND_MUL) || (s2_kind_r == KIND_TMUL) ||
            (s2_kind_r == KIND_FMA))) begin
        res[COMP_MASK[m]] = s2_lin_r[COMP_MASK[m]];
      end
    end
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_vld_r) begin
      out_y_r <= res;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.y_real = out_y_r[0];
  assign out_ch.y_e1   = out_y_r[1];
  assign out_ch.y_e2   = out_y_r[2];
  assign out_ch.y_e3   = out_y_r[3];
  assign out_ch.y_e12  = out_y_r[4];
  assign out_ch.y_e13  = out_y_r[5];
  assign out_ch.y_e23  = out_y_r[6];
  assign out_ch.y_e123 = out_y_r[7];

endmodule
